@@ hdl/value_noise_fbm_macros.svh @@
//------------------------------------------------------------------------------
// Value noise fBm assertion macros
// Short forms for the concurrent checks on the block's ports.
//------------------------------------------------------------------------------
`ifndef VALUE_NOISE_FBM_MACROS_SVH
`define VALUE_NOISE_FBM_MACROS_SVH

// Overlapping implication, clocked on clk and disabled during reset.
`define VNF_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("value noise check failed");

// Implication checked in the next cycle, clocked on clk and disabled during reset.
`define VNF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("value noise check failed");

`endif

@@ hdl/vnf_pkg.sv @@
//------------------------------------------------------------------------------
// Value noise fBm package
// Types and constants for the fractal value noise block.
//------------------------------------------------------------------------------
package vnf_pkg;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_DIV,
    ST_AMP,
    ST_IDLE
  } state_t;

  typedef enum logic [2:0] {
    STEP_MOD,
    STEP_MUL,
    STEP_QUO,
    STEP_REM,
    STEP_OFS
  } step_t;

  localparam logic [1:0] REG_SEED        = 2'd0;
  localparam logic [1:0] REG_OCTAVE      = 2'd1;
  localparam logic [1:0] REG_PERSISTENCE = 2'd2;

  localparam logic [30:0] SEED_RESET        = 31'd1;
  localparam logic [3:0]  OCTAVE_RESET      = 4'd4;
  localparam logic [15:0] PERSISTENCE_RESET = 16'd32768;

  localparam logic [31:0] HASH_ROW   = 32'd57;
  localparam logic [31:0] HASH_MUL   = 32'd15731;
  localparam logic [31:0] HASH_ADD_A = 32'd789221;
  localparam logic [31:0] HASH_ADD_B = 32'd1376312589;

  localparam logic [31:0] CORNER_OFS [4] = '{32'd0, 32'd1, 32'd57, 32'd58};

  // The seed modulus of 10000 is 16 times 625; the quotient by 625 uses the
  // reciprocal rounded up at a scale of 2^37.
  localparam logic [27:0] SEED_RECIP  = 28'd219902326;
  localparam logic [9:0]  SEED_DIV_HI = 10'd625;
  localparam logic [5:0]  OX_MUL      = 6'd37;
  localparam logic [5:0]  OY_MUL      = 6'd53;
  // Division by 25 of values below 2^20, reciprocal at a scale of 2^25.
  localparam logic [20:0] RECIP_25    = 21'd1342178;
  localparam logic [4:0]  DIV_25      = 5'd25;
  localparam logic [19:0] OFS_BIAS    = 20'd12;

  localparam logic [16:0] AMP_ONE   = 17'd65536;
  localparam logic [16:0] NOISE_MAX = 17'd65536;

endpackage

@@ hdl/value_noise_fbm.sv @@
// Throughput: one sample per cycle while busy is low; every octave has its own lane of hash
// and blend stages, and the final normalisation is a one-bit-per-stage divider pipeline.
// After reset and after every register write, busy stays high while the seed offsets and
// octave amplitudes are worked out by a short multiply sequence.
// Results are shown for one cycle with done; the receiver cannot stall the block.
//------------------------------------------------------------------------------
// Value noise fBm
// Fractal value noise on a 2-D Q16.16 point, normalised result in Q2.16.
//------------------------------------------------------------------------------
module value_noise_fbm #(
  parameter int MAX_OCTAVES = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] x_coord,
  input  logic signed [31:0] y_coord,
  output logic               done,
  output logic signed [17:0] noise_value,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import vnf_pkg::*;

  localparam int LVL    = (MAX_OCTAVES > 1) ? $clog2(MAX_OCTAVES) : 0;
  localparam int NP2    = 1 << LVL;
  localparam int IDX_W  = (MAX_OCTAVES > 1) ? $clog2(MAX_OCTAVES) : 1;
  localparam int CNT_W  = $clog2(MAX_OCTAVES + 1);
  localparam int AS_W   = 16 + CNT_W;
  localparam int PROD_W = 50;
  localparam int TW     = PROD_W + LVL;
  localparam int QB     = 17;
  localparam int RW     = AS_W + 14 + QB;
  localparam int VL     = 28 + LVL;

  function automatic logic [16:0] weight_f(input logic [31:0] fsq, input logic [17:0] ft);
    logic [49:0] p;
    p = 50'(fsq) * 50'(ft) + 50'h0_8000_0000;
    return p[48:32];
  endfunction

  function automatic logic signed [31:0] lerp_f(input logic signed [31:0] a,
                                                input logic signed [31:0] b,
                                                input logic [16:0] w);
    logic signed [32:0] diff;
    logic signed [50:0] t;
    logic signed [34:0] sh;
    diff = 33'(b) - 33'(a);
    t    = diff * $signed({1'b0, w}) + 51'sd32768;
    sh   = 35'(t >>> 16);
    return 32'(35'(a) + sh);
  endfunction

  function automatic logic signed [31:0] corner_f(input logic [31:0] n, input logic [31:0] q);
    logic [31:0] r;
    r = n * q + HASH_ADD_B;
    return 32'sd1073741824 - $signed({1'b0, r[30:0]});
  endfunction

  function automatic logic [15:0] div25_f(input logic [19:0] z);
    logic [40:0] p;
    p = 41'(z) * 41'(RECIP_25);
    return p[40:25];
  endfunction

  // Configuration registers and set-up sequencer.
  logic [30:0] seed;
  logic [3:0]  octave_count;
  logic [15:0] persistence;
  logic        cfg_we;
  logic        accept;

  state_t state, state_next;
  step_t  step;
  logic [54:0]       seed_prod;
  logic [17:0]       q625;
  logic [13:0]       sm;
  logic [19:0]       bx;
  logic [19:0]       by;
  logic [15:0]       qbx;
  logic [15:0]       qby;
  logic [4:0]        rbx;
  logic [4:0]        rby;
  logic [28:0]       ox;
  logic [28:0]       oy;
  logic [16:0]       amp_cur;
  logic [32:0]       amp_prod;
  logic [16:0]       amp_sel;
  logic [IDX_W-1:0]  aidx;
  logic [CNT_W-1:0]  oct_eff;
  logic [16:0]       amp [MAX_OCTAVES];
  logic [AS_W-1:0]   amp_sum;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid & cfg_ready;
  assign accept    = start & ~busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed         <= SEED_RESET;
      octave_count <= OCTAVE_RESET;
      persistence  <= PERSISTENCE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SEED:        seed         <= cfg_data[30:0];
        REG_OCTAVE:      octave_count <= cfg_data[3:0];
        REG_PERSISTENCE: persistence  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      state <= ST_LOAD;
      step  <= STEP_MOD;
    end else begin
      state <= state_next;
      if (state == ST_DIV) begin
        unique case (step)
          STEP_MOD: step <= STEP_MUL;
          STEP_MUL: step <= STEP_QUO;
          STEP_QUO: step <= STEP_REM;
          STEP_REM: step <= STEP_OFS;
          default:  step <= STEP_OFS;
        endcase
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD: state_next = ST_DIV;
      ST_DIV: begin
        if (step == STEP_OFS) begin
          state_next = ST_AMP;
        end
      end
      ST_AMP: begin
        if (aidx == IDX_W'(MAX_OCTAVES - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: state_next = ST_IDLE;
      default: state_next = ST_LOAD;
    endcase
  end

  always_comb begin
    busy = (state != ST_IDLE);
  end

  always_comb begin
    seed_prod = 55'(seed[30:4]) * 55'(SEED_RECIP);
    if (octave_count == 4'd0) begin
      oct_eff = CNT_W'(1);
    end else if (int'(octave_count) > MAX_OCTAVES) begin
      oct_eff = CNT_W'(MAX_OCTAVES);
    end else begin
      oct_eff = CNT_W'(octave_count);
    end
    amp_prod = 33'(amp_cur) * 33'(persistence) + 33'd32768;
    amp_sel  = (CNT_W'(aidx) < oct_eff) ? amp_cur : 17'd0;
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_LOAD: begin
        q625 <= seed_prod[54:37];
      end
      ST_DIV: begin
        unique case (step)
          STEP_MOD: begin
            sm <= {10'(seed[30:4] - 27'(q625) * 27'(SEED_DIV_HI)), seed[3:0]};
          end
          STEP_MUL: begin
            bx <= 20'(sm) * 20'(OX_MUL);
            by <= 20'(sm) * 20'(OY_MUL);
          end
          STEP_QUO: begin
            qbx <= div25_f(bx);
            qby <= div25_f(by);
          end
          STEP_REM: begin
            rbx <= 5'(bx - 20'(qbx) * 20'(DIV_25));
            rby <= 5'(by - 20'(qby) * 20'(DIV_25));
          end
          default: begin
            ox      <= 29'({qbx, 14'd0}) + 29'(div25_f({rbx, 14'd0} + OFS_BIAS));
            oy      <= 29'({qby, 14'd0}) + 29'(div25_f({rby, 14'd0} + OFS_BIAS));
            amp_cur <= AMP_ONE;
            aidx    <= '0;
            amp_sum <= '0;
          end
        endcase
      end
      ST_AMP: begin
        amp[aidx] <= amp_sel;
        amp_sum   <= amp_sum + AS_W'(amp_sel);
        amp_cur   <= amp_prod[32:16];
        aidx      <= aidx + IDX_W'(1);
      end
      default: ;
    endcase
  end

  // Octave lanes.
  logic signed [31:0] x_r, y_r;
  logic [47:0] xs, ys;
  logic [47:0] px [MAX_OCTAVES];
  logic [47:0] py [MAX_OCTAVES];
  logic [31:0] base [MAX_OCTAVES];
  logic [31:0] cn   [MAX_OCTAVES][4];
  logic [31:0] hn1  [MAX_OCTAVES][4];
  logic [31:0] hn2  [MAX_OCTAVES][4];
  logic [31:0] hn3  [MAX_OCTAVES][4];
  logic [31:0] hsq  [MAX_OCTAVES][4];
  logic [31:0] hq   [MAX_OCTAVES][4];
  logic signed [31:0] hv [MAX_OCTAVES][4];
  logic [31:0] fsqx [MAX_OCTAVES];
  logic [31:0] fsqy [MAX_OCTAVES];
  logic [17:0] ftx  [MAX_OCTAVES];
  logic [17:0] fty  [MAX_OCTAVES];
  logic [16:0] wu3 [MAX_OCTAVES];
  logic [16:0] wv3 [MAX_OCTAVES];
  logic [16:0] wu4 [MAX_OCTAVES];
  logic [16:0] wv4 [MAX_OCTAVES];
  logic [16:0] wu5 [MAX_OCTAVES];
  logic [16:0] wv5 [MAX_OCTAVES];
  logic [16:0] wv6 [MAX_OCTAVES];
  logic signed [31:0] l0 [MAX_OCTAVES];
  logic signed [31:0] l1 [MAX_OCTAVES];
  logic signed [31:0] nv [MAX_OCTAVES];
  logic signed [PROD_W-1:0] prod [MAX_OCTAVES];
  logic signed [TW-1:0] tree [LVL+1][NP2];

  assign xs = {{16{x_r[31]}}, x_r};
  assign ys = {{16{y_r[31]}}, y_r};

  always_comb begin
    for (int i = 0; i < MAX_OCTAVES; i++) begin
      base[i] = px[i][47:16] + py[i][47:16] * HASH_ROW + {1'b0, seed};
      for (int j = 0; j < 4; j++) begin
        cn[i][j] = base[i] + CORNER_OFS[j];
      end
      prod[i] = nv[i] * $signed({1'b0, amp[i]});
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_coord;
    y_r <= y_coord;
    for (int i = 0; i < MAX_OCTAVES; i++) begin
      px[i]   <= (xs << i) + 48'(ox);
      py[i]   <= (ys << i) + 48'(oy);
      fsqx[i] <= 32'(px[i][15:0]) * 32'(px[i][15:0]);
      fsqy[i] <= 32'(py[i][15:0]) * 32'(py[i][15:0]);
      ftx[i]  <= 18'd196608 - 18'({px[i][15:0], 1'b0});
      fty[i]  <= 18'd196608 - 18'({py[i][15:0], 1'b0});
      wu3[i]  <= weight_f(fsqx[i], ftx[i]);
      wv3[i]  <= weight_f(fsqy[i], fty[i]);
      wu4[i]  <= wu3[i];
      wv4[i]  <= wv3[i];
      wu5[i]  <= wu4[i];
      wv5[i]  <= wv4[i];
      wv6[i]  <= wv5[i];
      for (int j = 0; j < 4; j++) begin
        hn1[i][j] <= (cn[i][j] << 13) ^ cn[i][j];
        hn2[i][j] <= hn1[i][j];
        hsq[i][j] <= hn1[i][j] * hn1[i][j];
        hn3[i][j] <= hn2[i][j];
        hq[i][j]  <= hsq[i][j] * HASH_MUL + HASH_ADD_A;
        hv[i][j]  <= corner_f(hn3[i][j], hq[i][j]);
      end
      l0[i] <= lerp_f(hv[i][0], hv[i][1], wu5[i]);
      l1[i] <= lerp_f(hv[i][2], hv[i][3], wu5[i]);
      nv[i] <= lerp_f(l0[i], l1[i], wv6[i]);
      tree[0][i] <= TW'(prod[i]);
    end
    for (int i = MAX_OCTAVES; i < NP2; i++) begin
      tree[0][i] <= '0;
    end
    for (int l = 0; l < LVL; l++) begin
      for (int j = 0; j < NP2; j++) begin
        if (j < (NP2 >> (l + 1))) begin
          tree[l+1][j] <= tree[l][2*j] + tree[l][2*j+1];
        end else begin
          tree[l+1][j] <= '0;
        end
      end
    end
  end

  // Normalisation by the amplitude total, one quotient bit per stage.
  logic signed [TW-1:0] total;
  logic [TW-1:0]        mag;
  logic [RW-1:0]        num;
  logic                 neg0;
  logic [RW-1:0]        den;
  logic [RW-1:0]        dsrc [QB];
  logic [QB-1:0]        qsrc [QB];
  logic [RW-1:0]        dsub [QB];
  logic [RW-1:0]        drem [QB];
  logic [QB-1:0]        dq   [QB];
  logic                 dneg [QB];
  logic [QB-1:0]        qfin;
  logic [QB-1:0]        qclamp;

  assign total = tree[LVL][0];
  assign mag   = total[TW-1] ? TW'(-total) : TW'(total);
  assign den   = RW'({amp_sum, 14'd0});

  always_comb begin
    for (int k = 0; k < QB; k++) begin
      dsrc[k] = (k == 0) ? num : drem[(k == 0) ? 0 : k - 1];
      qsrc[k] = (k == 0) ? '0 : dq[(k == 0) ? 0 : k - 1];
      dsub[k] = den << (QB - 1 - k);
    end
    qfin   = dq[QB-1];
    qclamp = (qfin > NOISE_MAX) ? NOISE_MAX : qfin;
  end

  always_ff @(posedge clk) begin
    num  <= RW'(mag) + RW'({amp_sum, 13'd0});
    neg0 <= total[TW-1];
    for (int k = 0; k < QB; k++) begin
      if (dsrc[k] >= dsub[k]) begin
        drem[k] <= dsrc[k] - dsub[k];
        dq[k]   <= {qsrc[k][QB-2:0], 1'b1};
      end else begin
        drem[k] <= dsrc[k];
        dq[k]   <= {qsrc[k][QB-2:0], 1'b0};
      end
      dneg[k] <= (k == 0) ? neg0 : dneg[(k == 0) ? 0 : k - 1];
    end
    noise_value <= dneg[QB-1] ? -$signed({1'b0, qclamp}) : $signed({1'b0, qclamp});
  end

  // Beat valid chain.
  logic [VL-1:0] vp;

  always_ff @(posedge clk) begin
    if (rst) begin
      vp <= '0;
    end else begin
      vp <= {vp[VL-2:0], accept};
    end
  end

  assign done = vp[VL-1];

endmodule

@@ hdl/vnf_checker.sv @@
//------------------------------------------------------------------------------
// Value noise fBm checker
// Port-level checks on latency, set-up and result range.
//------------------------------------------------------------------------------
`include "value_noise_fbm_macros.svh"

module vnf_checker #(
  parameter int MAX_OCTAVES = 8
) (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input logic signed [17:0] noise_value,
  input logic               cfg_valid,
  input logic               cfg_ready
);
  localparam int LVL = (MAX_OCTAVES > 1) ? $clog2(MAX_OCTAVES) : 0;
  localparam int LAT = 28 + LVL;

  `VNF_ASSERT_IMPL(a_beat_done, start && !busy, ##LAT done)
  `VNF_ASSERT_IMPL(a_done_beat, done, $past(start && !busy, LAT))
  `VNF_ASSERT_IMPL(a_range, done, noise_value <= 18'sd65536 && noise_value >= -18'sd65536)
  `VNF_ASSERT_NEXT(a_cfg_busy, cfg_valid && cfg_ready, busy)

endmodule

bind value_noise_fbm vnf_checker #(.MAX_OCTAVES(MAX_OCTAVES)) u_vnf_checker (.*);
